// ===== hw/rtl/fte_pkg.sv =====
`default_nettype none
package fte_pkg;

  localparam int CAPACITY = 1024;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int IDX_W    = 11;
  localparam int K_W      = IDX_W + 1;
  localparam int SUM_W    = 48;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_RANGE  = 2'd1,
    CMD_POINT  = 2'd2,
    CMD_LBOUND = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [IDX_W-1:0]   index_a;
    logic [IDX_W-1:0]   index_b;
    logic signed [47:0] value;
  } in_word_t;

  typedef struct packed {
    logic signed [47:0] sum_out;
    logic [IDX_W-1:0]   found_index;
    logic               index_error;
  } out_word_t;

endpackage
`default_nettype wire

// ===== hw/rtl/fte_node_ram.sv =====
`default_nettype none
module fte_node_ram #(
  parameter int DEPTH  = 1024,
  parameter int WIDTH  = 48,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output      logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ===== hw/rtl/fenwick_tree_engine.sv =====
`default_nettype none
// Fenwick tree engine: prefix-sum structure over up to 1024 signed 48-bit
// elements, with node storage in one single-port-read, single-port-write RAM.
// Command channel: drive in_data and raise start; the word is taken at a rising
// edge where start is high and busy is low. Commands: add delta at a position,
// range sum over [a, b), point value, lower bound on a prefix threshold.
// Result channel: out_valid is high for exactly one cycle with out_data; the
// receiver must take it then, it cannot hold the block off.
// Configuration: cfg_data (element count) is written when cfg_valid and
// cfg_ready are both high; cfg_ready is always high. Write only while idle.
// Sequencing: an out-of-range add or point value, or a lower bound with a
// threshold of zero or less, answers in the cycle after its word is taken.
// Add reads each visited node and writes it back while the next one is read.
// Range sum and point value walk two node chains, one RAM read per node.
// Lower bound spends a read state, then a compare state, on each in-range bit
// step, and passes through the read state without a read on each skipped step.
// busy drops as the result appears, so the next word is taken at the edge that
// takes the result.
// Reset: after rst_n is released the node RAM is cleared, one entry per cycle,
// and busy stays high meanwhile; configuration writes are still taken.
module fenwick_tree_engine (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output      logic                     busy,
  input  wire fte_pkg::in_word_t        in_data,
  output      logic                     out_valid,
  output      fte_pkg::out_word_t       out_data,
  input  wire logic                     cfg_valid,
  output      logic                     cfg_ready,
  input  wire logic [fte_pkg::IDX_W-1:0] cfg_data
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SUM,
    ST_ADD,
    ST_LB_RD,
    ST_LB_CMP
  } state_t;

  localparam logic [fte_pkg::IDX_W-1:0] CAP_IDX = fte_pkg::IDX_W'(fte_pkg::CAPACITY);

  state_t                          state_r, state_nxt;
  logic [fte_pkg::IDX_W-1:0]       count_r;
  logic [fte_pkg::K_W-1:0]         k_r, k_nxt;
  logic [fte_pkg::IDX_W-1:0]       wk_r, wk_nxt;
  logic                            pend_r, pend_nxt;
  logic                            neg_r, neg_nxt;
  logic [fte_pkg::IDX_W-1:0]       a_r, a_nxt;
  logic [fte_pkg::IDX_W-1:0]       pos_r, pos_nxt;
  logic [fte_pkg::K_W-1:0]         step_r, step_nxt;
  logic [fte_pkg::SUM_W-1:0]       acc_r, acc_nxt;
  logic [fte_pkg::SUM_W-1:0]       v_r, v_nxt;
  logic [fte_pkg::ADDR_W-1:0]      clr_r, clr_nxt;
  logic                            out_valid_r, out_valid_nxt;
  fte_pkg::out_word_t              out_data_r, out_data_nxt;

  logic [fte_pkg::IDX_W-1:0]       n_eff;
  logic [fte_pkg::K_W-1:0]         n_ext;
  logic [fte_pkg::K_W-1:0]         lowbit;
  logic [fte_pkg::K_W-1:0]         lb_k;
  logic [fte_pkg::K_W-1:0]         step_init;
  logic [fte_pkg::IDX_W-1:0]       a_clamp, b_clamp;
  logic                            accepted;

  logic                            mem_we, mem_re;
  logic [fte_pkg::ADDR_W-1:0]      mem_waddr, mem_raddr;
  logic [fte_pkg::SUM_W-1:0]       mem_wdata, mem_rdata;

  fte_node_ram #(
    .DEPTH  (fte_pkg::CAPACITY),
    .WIDTH  (fte_pkg::SUM_W),
    .ADDR_W (fte_pkg::ADDR_W)
  ) u_nodes (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  // effective count and helpers
  assign n_eff    = (count_r > CAP_IDX) ? CAP_IDX : count_r;
  assign n_ext    = {1'b0, n_eff};
  assign lowbit   = k_r & (~k_r + fte_pkg::K_W'(1));
  assign lb_k     = {1'b0, pos_r} + step_r;
  assign a_clamp  = (in_data.index_a > n_eff) ? n_eff : in_data.index_a;
  assign b_clamp  = (in_data.index_b > n_eff) ? n_eff : in_data.index_b;
  assign accepted = start && !busy;

  // smallest power of two above the count
  always_comb begin
    step_init = '0;
    for (int i = fte_pkg::K_W - 1; i >= 0; i--) begin
      if ((fte_pkg::K_W'(1) << i) > n_ext) begin
        step_init = fte_pkg::K_W'(1) << i;
      end
    end
  end

  // sequencer next state, RAM control
  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    wk_nxt        = wk_r;
    pend_nxt      = pend_r;
    neg_nxt       = neg_r;
    a_nxt         = a_r;
    pos_nxt       = pos_r;
    step_nxt      = step_r;
    acc_nxt       = acc_r;
    v_nxt         = v_r;
    clr_nxt       = clr_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;
    mem_re        = 1'b0;
    mem_raddr     = '0;

    case (state_r)
      ST_CLEAR: begin
        // zero one node per cycle
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        clr_nxt   = clr_r + fte_pkg::ADDR_W'(1);
        if (clr_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (accepted) begin
          out_data_nxt = '0;
          pend_nxt     = 1'b0;
          neg_nxt      = 1'b0;
          acc_nxt      = '0;
          v_nxt        = in_data.value;
          case (in_data.cmd)
            fte_pkg::CMD_ADD: begin
              if (in_data.index_a >= n_eff) begin
                out_data_nxt.index_error = 1'b1;
                out_valid_nxt            = 1'b1;
              end else begin
                k_nxt     = {1'b0, in_data.index_a} + fte_pkg::K_W'(1);
                state_nxt = ST_ADD;
              end
            end
            fte_pkg::CMD_RANGE: begin
              out_data_nxt.index_error = (in_data.index_a > n_eff) ||
                                         (in_data.index_b > n_eff);
              k_nxt     = {1'b0, b_clamp};
              a_nxt     = a_clamp;
              state_nxt = ST_SUM;
            end
            fte_pkg::CMD_POINT: begin
              if (in_data.index_a >= n_eff) begin
                out_data_nxt.index_error = 1'b1;
                out_valid_nxt            = 1'b1;
              end else begin
                k_nxt     = {1'b0, in_data.index_a} + fte_pkg::K_W'(1);
                a_nxt     = in_data.index_a;
                state_nxt = ST_SUM;
              end
            end
            default: begin
              if (in_data.value == '0 || in_data.value[fte_pkg::SUM_W-1]) begin
                out_valid_nxt = 1'b1;
              end else begin
                pos_nxt   = '0;
                step_nxt  = step_init;
                state_nxt = ST_LB_RD;
              end
            end
          endcase
        end
      end

      ST_SUM: begin
        // issue one node read per cycle, fold the returning one
        if (k_r != '0) begin
          mem_re    = 1'b1;
          mem_raddr = fte_pkg::ADDR_W'(k_r - fte_pkg::K_W'(1));
          k_nxt     = k_r - lowbit;
        end
        pend_nxt = (k_r != '0);
        if (pend_r) begin
          acc_nxt = neg_r ? (acc_r - mem_rdata) : (acc_r + mem_rdata);
        end
        if (k_r == '0 && !pend_r) begin
          if (!neg_r) begin
            neg_nxt = 1'b1;
            k_nxt   = {1'b0, a_r};
          end else begin
            out_data_nxt.sum_out = acc_r;
            out_valid_nxt        = 1'b1;
            state_nxt            = ST_IDLE;
          end
        end
      end

      ST_ADD: begin
        // read next node while the previous one is written back
        if (k_r <= n_ext) begin
          mem_re    = 1'b1;
          mem_raddr = fte_pkg::ADDR_W'(k_r - fte_pkg::K_W'(1));
          wk_nxt    = k_r[fte_pkg::IDX_W-1:0];
          k_nxt     = k_r + lowbit;
        end
        pend_nxt = (k_r <= n_ext);
        if (pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = fte_pkg::ADDR_W'(wk_r - fte_pkg::IDX_W'(1));
          mem_wdata = mem_rdata + v_r;
        end
        if (!(k_r <= n_ext) && !pend_r) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      ST_LB_RD: begin
        // probe the next candidate bit, skip it if out of range, or finish
        if (step_r == '0) begin
          out_data_nxt.found_index = pos_r;
          out_valid_nxt            = 1'b1;
          state_nxt                = ST_IDLE;
        end else if (lb_k <= n_ext) begin
          mem_re    = 1'b1;
          mem_raddr = fte_pkg::ADDR_W'(lb_k - fte_pkg::K_W'(1));
          k_nxt     = lb_k;
          state_nxt = ST_LB_CMP;
        end else begin
          step_nxt = step_r >> 1;
        end
      end

      ST_LB_CMP: begin
        // take the node when its sum stays below the threshold
        if ($signed(mem_rdata) < $signed(v_r)) begin
          v_nxt   = v_r - mem_rdata;
          pos_nxt = k_r[fte_pkg::IDX_W-1:0];
        end
        step_nxt  = step_r >> 1;
        state_nxt = ST_LB_RD;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= CAP_IDX;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        count_r <= cfg_data;
      end
    end
    k_r        <= k_nxt;
    wk_r       <= wk_nxt;
    neg_r      <= neg_nxt;
    a_r        <= a_nxt;
    pos_r      <= pos_nxt;
    step_r     <= step_nxt;
    acc_r      <= acc_nxt;
    v_r        <= v_nxt;
    out_data_r <= out_data_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  // a read and a write-back never hit the same node in one cycle
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("node read and write-back collide");

  // lower bound probes one bit at a time
  a_step_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LB_RD || state_r == ST_LB_CMP) |-> $onehot0(step_r))
    else $error("lower bound step is not a single bit");

  // an accepted command either starts work or answers at once
  a_cmd_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted command dropped");

  // a result only follows an accepted command or ongoing work
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy || start))
    else $error("result without a command");

endmodule
`default_nettype wire
